// ----- src/basic_source_tokenizer_core_defines.svh -----
// assertion macros shared by the tokenizer
`ifndef BASIC_SOURCE_TOKENIZER_CORE_DEFINES_SVH
`define BASIC_SOURCE_TOKENIZER_CORE_DEFINES_SVH

// condition in the same cycle implies a property in that cycle
`define BSTOK_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition in one cycle implies a property in the next
`define BSTOK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/bstok_pkg.sv -----
package bstok_pkg;

   localparam logic [2:0] KIND_IDENT     = 3'd0;
   localparam logic [2:0] KIND_NUMBER    = 3'd1;
   localparam logic [2:0] KIND_OPERATOR  = 3'd2;
   localparam logic [2:0] KIND_STRING    = 3'd3;
   localparam logic [2:0] KIND_SEPARATOR = 3'd4;
   localparam logic [2:0] KIND_EXPR_END  = 3'd5;
   localparam logic [2:0] KIND_UNKNOWN   = 3'd6;

   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_VTAB      = 8'd11;
   localparam logic [7:0] CHAR_FORMFEED  = 8'd12;
   localparam logic [7:0] CHAR_RETURN    = 8'd13;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_DOLLAR    = 8'h24;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_IDENT  = 4'b0010,
      MODE_NUMBER = 4'b0100,
      MODE_STRING = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic       has_byte;
      logic       tok_start;
      logic       tok_end;
      logic       last;
   } item_type;

endpackage

// ----- src/bstok_lexer.sv -----
module bstok_lexer (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         text_byte,
   input  logic               end_of_input,
   output logic [1:0]         item_count,
   output bstok_pkg::item_type item0,
   output bstok_pkg::item_type item1
);

   bstok_pkg::mode_type mode_ff, mode_in;
   logic                esc_ff, esc_in;
   logic                line_ff, line_in;
   bstok_pkg::item_type slot [2];

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return b == bstok_pkg::CHAR_SPACE || b == bstok_pkg::CHAR_TAB ||
             b == bstok_pkg::CHAR_VTAB || b == bstok_pkg::CHAR_FORMFEED ||
             b == bstok_pkg::CHAR_RETURN;
   endfunction

   function automatic logic is_operator(input logic [7:0] b);
      return b == bstok_pkg::CHAR_EQUALS || b == bstok_pkg::CHAR_PLUS ||
             b == bstok_pkg::CHAR_MINUS || b == bstok_pkg::CHAR_STAR ||
             b == bstok_pkg::CHAR_SLASH;
   endfunction

   function automatic bstok_pkg::item_type make_item(input logic [2:0] kind,
                                                    input logic [7:0] value,
                                                    input logic       has,
                                                    input logic       st,
                                                    input logic       en);
      bstok_pkg::item_type it;
      it.kind      = kind;
      it.value     = has ? value : 8'd0;
      it.has_byte  = has;
      it.tok_start = st;
      it.tok_end   = en;
      it.last      = 1'b0;
      return it;
   endfunction

   function automatic logic [2:0] mode_kind(input bstok_pkg::mode_type m);
      logic [2:0] k;
      unique case (m)
         bstok_pkg::MODE_IDENT:  k = bstok_pkg::KIND_IDENT;
         bstok_pkg::MODE_NUMBER: k = bstok_pkg::KIND_NUMBER;
         default:                k = bstok_pkg::KIND_STRING;
      endcase
      return k;
   endfunction

   always_comb begin
      logic       cont;
      logic       open;
      bstok_pkg::item_type close_item;
      bstok_pkg::item_type eol_item;
      bstok_pkg::item_type fresh;
      logic       fresh_valid;

      item_count = 2'd0;
      slot[0]    = '0;
      slot[1]    = '0;
      mode_in    = mode_ff;
      esc_in     = esc_ff;
      line_in    = line_ff;
      cont       = 1'b0;
      open       = (mode_ff != bstok_pkg::MODE_IDLE);
      close_item = make_item(mode_kind(mode_ff), 8'd0, 1'b0, 1'b0, 1'b1);
      eol_item   = make_item(bstok_pkg::KIND_EXPR_END, bstok_pkg::CHAR_NEWLINE,
                             1'b1, 1'b1, 1'b1);
      fresh       = '0;
      fresh_valid = 1'b0;

      if (end_of_input || text_byte == bstok_pkg::CHAR_NEWLINE) begin
         if (open) begin
            slot[item_count[0]] = close_item;
            item_count = item_count + 2'd1;
         end
         // end of input on an empty line is silent
         if (!end_of_input || line_ff) begin
            slot[item_count[0]] = eol_item;
            item_count = item_count + 2'd1;
         end
         mode_in = bstok_pkg::MODE_IDLE;
         esc_in  = 1'b0;
         line_in = 1'b0;
      end else begin
         line_in = 1'b1;
         if (mode_ff == bstok_pkg::MODE_STRING) begin
            if (esc_ff) begin
               esc_in = 1'b0;
               slot[0] = make_item(bstok_pkg::KIND_STRING, text_byte, 1'b1, 1'b0, 1'b0);
               item_count = 2'd1;
            end else if (text_byte == bstok_pkg::CHAR_BACKSLASH) begin
               esc_in = 1'b1;
            end else if (text_byte == bstok_pkg::CHAR_QUOTE) begin
               slot[0] = close_item;
               item_count = 2'd1;
               mode_in = bstok_pkg::MODE_IDLE;
               esc_in  = 1'b0;
            end else begin
               slot[0] = make_item(bstok_pkg::KIND_STRING, text_byte, 1'b1, 1'b0, 1'b0);
               item_count = 2'd1;
            end
         end else begin
            if (mode_ff == bstok_pkg::MODE_IDENT &&
                (is_letter(text_byte) || is_digit(text_byte) ||
                 text_byte == bstok_pkg::CHAR_DOLLAR)) begin
               slot[0] = make_item(bstok_pkg::KIND_IDENT, text_byte, 1'b1, 1'b0, 1'b0);
               item_count = 2'd1;
               cont = 1'b1;
            end else if (mode_ff == bstok_pkg::MODE_NUMBER && is_digit(text_byte)) begin
               slot[0] = make_item(bstok_pkg::KIND_NUMBER, text_byte, 1'b1, 1'b0, 1'b0);
               item_count = 2'd1;
               cont = 1'b1;
            end else if (open) begin
               slot[0] = close_item;
               item_count = 2'd1;
               mode_in = bstok_pkg::MODE_IDLE;
               esc_in  = 1'b0;
            end

            if (!cont) begin
               fresh_valid = 1'b1;
               if (is_blank(text_byte)) begin
                  fresh_valid = 1'b0;
               end else if (is_letter(text_byte)) begin
                  mode_in = bstok_pkg::MODE_IDENT;
                  fresh = make_item(bstok_pkg::KIND_IDENT, text_byte, 1'b1, 1'b1, 1'b0);
               end else if (is_digit(text_byte)) begin
                  mode_in = bstok_pkg::MODE_NUMBER;
                  fresh = make_item(bstok_pkg::KIND_NUMBER, text_byte, 1'b1, 1'b1, 1'b0);
               end else if (is_operator(text_byte)) begin
                  fresh = make_item(bstok_pkg::KIND_OPERATOR, text_byte, 1'b1, 1'b1, 1'b1);
               end else if (text_byte == bstok_pkg::CHAR_QUOTE) begin
                  mode_in = bstok_pkg::MODE_STRING;
                  esc_in  = 1'b0;
                  fresh = make_item(bstok_pkg::KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b0);
               end else if (text_byte == bstok_pkg::CHAR_COMMA) begin
                  fresh = make_item(bstok_pkg::KIND_SEPARATOR, text_byte, 1'b1, 1'b1, 1'b1);
               end else if (text_byte == bstok_pkg::CHAR_SEMICOLON) begin
                  fresh = make_item(bstok_pkg::KIND_EXPR_END, text_byte, 1'b1, 1'b1, 1'b1);
               end else begin
                  fresh = make_item(bstok_pkg::KIND_UNKNOWN, text_byte, 1'b1, 1'b1, 1'b1);
               end
               if (fresh_valid) begin
                  slot[item_count[0]] = fresh;
                  item_count = item_count + 2'd1;
               end
            end
         end
      end

      // flag the final item of this request
      if (item_count == 2'd2) begin
         slot[1].last = 1'b1;
      end else if (item_count == 2'd1) begin
         slot[0].last = 1'b1;
      end
   end

   assign item0 = slot[0];
   assign item1 = slot[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bstok_pkg::MODE_IDLE;
         esc_ff  <= 1'b0;
         line_ff <= 1'b0;
      end else if (fire) begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         line_ff <= line_in;
      end
   end

endmodule

// ----- src/bstok_result_buffer.sv -----
module bstok_result_buffer (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_count,
   input  bstok_pkg::item_type push0,
   input  bstok_pkg::item_type push1,
   output logic [1:0]         space,
   output logic               out_valid,
   input  logic               out_ready,
   output bstok_pkg::item_type out_item
);

   bstok_pkg::item_type slot0_ff, slot0_in;
   bstok_pkg::item_type slot1_ff, slot1_in;
   logic [1:0]          count_ff, count_in;
   logic                pop;
   logic [1:0]          remain;

   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot0_ff;
   assign pop       = out_valid && out_ready;
   assign remain    = count_ff - {1'b0, pop};
   assign space     = 2'd2 - remain;

   always_comb begin
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      // new items append behind whatever stays after the pop
      if (push_count != 2'd0) begin
         if (remain == 2'd0) begin
            slot0_in = push0;
         end else begin
            slot1_in = push0;
         end
      end
      if (push_count == 2'd2) begin
         slot1_in = push1;
      end
      count_in = remain + push_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ----- src/basic_source_tokenizer_core.sv -----
// an accepted request is registered; its results pass via the result buffer to the outputs
// throughput: one request per cycle while rsp_ready is high and each byte gives at most
// one result; a byte that closes a token and opens another fills the two-entry result
// buffer with both of its results
// reset: synchronous, clears the lexer mode, escape and line flags and empties the buffers
module basic_source_tokenizer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_token_kind,
   output logic [7:0] rsp_value_byte,
   output logic       rsp_has_byte,
   output logic       rsp_token_start,
   output logic       rsp_token_end,
   output logic       rsp_last_result
);

`include "basic_source_tokenizer_core_defines.svh"

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          text_ff;
   logic                eoi_ff;
   logic                fire;
   logic [1:0]          item_count;
   logic [1:0]          space;
   bstok_pkg::item_type item0, item1, head;

   // the held request is consumed once its results fit in the buffer
   assign fire        = in_valid_ff && (item_count <= space);
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         text_ff <= req_text_byte;
         eoi_ff  <= req_end_of_input;
      end
   end

   bstok_lexer u_lexer (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .text_byte    (text_ff),
      .end_of_input (eoi_ff),
      .item_count   (item_count),
      .item0        (item0),
      .item1        (item1)
   );

   bstok_result_buffer u_buffer (
      .clock      (clock),
      .reset      (reset),
      .push_count (fire ? item_count : 2'd0),
      .push0      (item0),
      .push1      (item1),
      .space      (space),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_item   (head)
   );

   assign rsp_token_kind  = head.kind;
   assign rsp_value_byte  = head.value;
   assign rsp_has_byte    = head.has_byte;
   assign rsp_token_start = head.tok_start;
   assign rsp_token_end   = head.tok_end;
   assign rsp_last_result = head.last;

   `BSTOK_ASSERT_NEXT(a_held_request_kept, in_valid_ff && !fire, in_valid_ff, "request lost")
   `BSTOK_ASSERT_NOW(a_pair_last_flag, in_valid_ff && item_count == 2'd2, !item0.last && item1.last, "last flag misplaced")
   `BSTOK_ASSERT_NOW(a_no_byte_zero, rsp_valid && !rsp_has_byte, rsp_value_byte == 8'd0, "stray value byte")

endmodule

// ----- tb/basic_source_tokenizer_core_test.sv -----
module basic_source_tokenizer_core_test;

   localparam int RANDOM_REQUESTS = 800;
   localparam int STALL_LIMIT     = 1000;
   localparam int DRAIN_CYCLES    = 8;

   // how a directed row is checked
   typedef enum logic [1:0] {
      ROW_PREDICTED,
      ROW_SINGLE,
      ROW_SILENT
   } row_check_type;

   typedef struct packed {
      logic [7:0]    text;
      logic          eoi;
      row_check_type check;
      logic [2:0]    kind;
   } directed_row_type;

   // single-byte tokens carry the request byte as value, so only the kind is typed in
   localparam directed_row_type DIRECTED [25] = '{
      '{8'hA5,                     1'b1, ROW_SILENT,    bstok_pkg::KIND_UNKNOWN},
      '{8'h00,                     1'b0, ROW_SINGLE,    bstok_pkg::KIND_UNKNOWN},
      '{8'hFF,                     1'b0, ROW_SINGLE,    bstok_pkg::KIND_UNKNOWN},
      '{bstok_pkg::CHAR_EQUALS,    1'b0, ROW_SINGLE,    bstok_pkg::KIND_OPERATOR},
      '{bstok_pkg::CHAR_PLUS,      1'b0, ROW_SINGLE,    bstok_pkg::KIND_OPERATOR},
      '{bstok_pkg::CHAR_MINUS,     1'b0, ROW_SINGLE,    bstok_pkg::KIND_OPERATOR},
      '{bstok_pkg::CHAR_STAR,      1'b0, ROW_SINGLE,    bstok_pkg::KIND_OPERATOR},
      '{bstok_pkg::CHAR_SLASH,     1'b0, ROW_SINGLE,    bstok_pkg::KIND_OPERATOR},
      '{bstok_pkg::CHAR_COMMA,     1'b0, ROW_SINGLE,    bstok_pkg::KIND_SEPARATOR},
      '{bstok_pkg::CHAR_SEMICOLON, 1'b0, ROW_SINGLE,    bstok_pkg::KIND_EXPR_END},
      '{8'h41,                     1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{8'h7A,                     1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{bstok_pkg::CHAR_DOLLAR,    1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{8'h39,                     1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{bstok_pkg::CHAR_SPACE,     1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{8'h30,                     1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{bstok_pkg::CHAR_NEWLINE,   1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{bstok_pkg::CHAR_QUOTE,     1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{bstok_pkg::CHAR_BACKSLASH, 1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{bstok_pkg::CHAR_QUOTE,     1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{bstok_pkg::CHAR_BACKSLASH, 1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{bstok_pkg::CHAR_NEWLINE,   1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{bstok_pkg::CHAR_QUOTE,     1'b0, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{8'h5A,                     1'b1, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN},
      '{bstok_pkg::CHAR_NEWLINE,   1'b0, ROW_SINGLE,    bstok_pkg::KIND_EXPR_END}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_token_kind;
   logic [7:0] rsp_value_byte;
   logic       rsp_has_byte;
   logic       rsp_token_start;
   logic       rsp_token_end;
   logic       rsp_last_result;

   basic_source_tokenizer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_value_byte   (rsp_value_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_end    (rsp_token_end),
      .rsp_last_result  (rsp_last_result)
   );

   // lexer state mirrored by the testbench
   bstok_pkg::mode_type lex_state   = bstok_pkg::MODE_IDLE;
   logic                esc_pending = 1'b0;
   logic                line_busy   = 1'b0;

   bstok_pkg::item_type expected_tokens [$];
   bstok_pkg::item_type oldest;
   int                  errors = 0;
   int                  stall_cycles = 0;
   logic                calm = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bstok_pkg::item_type make_item(logic [2:0] kind, logic [7:0] value,
                                                     logic has, logic first,
                                                     logic closing);
      bstok_pkg::item_type it;
      it.kind      = kind;
      it.value     = has ? value : 8'h00;
      it.has_byte  = has;
      it.tok_start = first;
      it.tok_end   = closing;
      it.last      = 1'b0;
      return it;
   endfunction

   function automatic void queue_expected(bstok_pkg::item_type it);
      expected_tokens.insert(expected_tokens.size(), it);
   endfunction

   function automatic logic is_letter(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   // advances the mirrored lexer by one request; keep selects whether its tokens are expected
   function automatic void tokenize_byte(logic [7:0] b, logic eoi, logic keep);
      bstok_pkg::item_type got [2];
      int                  n;
      logic [2:0]          open_kind;
      n = 0;
      open_kind = (lex_state == bstok_pkg::MODE_IDENT)  ? bstok_pkg::KIND_IDENT :
                  (lex_state == bstok_pkg::MODE_NUMBER) ? bstok_pkg::KIND_NUMBER :
                  bstok_pkg::KIND_STRING;
      if (eoi || b == bstok_pkg::CHAR_NEWLINE) begin
         if (lex_state != bstok_pkg::MODE_IDLE) begin
            got[n] = make_item(open_kind, 8'h00, 1'b0, 1'b0, 1'b1);
            n++;
         end
         // end of input on an empty line is silent
         if (!eoi || line_busy) begin
            got[n] = make_item(bstok_pkg::KIND_EXPR_END, bstok_pkg::CHAR_NEWLINE,
                               1'b1, 1'b1, 1'b1);
            n++;
         end
         lex_state   = bstok_pkg::MODE_IDLE;
         esc_pending = 1'b0;
         line_busy   = 1'b0;
      end else if (lex_state == bstok_pkg::MODE_STRING) begin
         line_busy = 1'b1;
         if (esc_pending) begin
            esc_pending = 1'b0;
            got[n] = make_item(bstok_pkg::KIND_STRING, b, 1'b1, 1'b0, 1'b0);
            n++;
         end else if (b == bstok_pkg::CHAR_BACKSLASH) begin
            esc_pending = 1'b1;
         end else if (b == bstok_pkg::CHAR_QUOTE) begin
            got[n] = make_item(bstok_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1);
            n++;
            lex_state = bstok_pkg::MODE_IDLE;
         end else begin
            got[n] = make_item(bstok_pkg::KIND_STRING, b, 1'b1, 1'b0, 1'b0);
            n++;
         end
      end else begin
         line_busy = 1'b1;
         if ((lex_state == bstok_pkg::MODE_IDENT &&
              (is_letter(b) || is_digit(b) || b == bstok_pkg::CHAR_DOLLAR)) ||
             (lex_state == bstok_pkg::MODE_NUMBER && is_digit(b))) begin
            got[n] = make_item(open_kind, b, 1'b1, 1'b0, 1'b0);
            n++;
         end else begin
            if (lex_state != bstok_pkg::MODE_IDLE) begin
               got[n] = make_item(open_kind, 8'h00, 1'b0, 1'b0, 1'b1);
               n++;
               lex_state = bstok_pkg::MODE_IDLE;
            end
            if (b == bstok_pkg::CHAR_SPACE || b == bstok_pkg::CHAR_TAB ||
                b == bstok_pkg::CHAR_VTAB || b == bstok_pkg::CHAR_FORMFEED ||
                b == bstok_pkg::CHAR_RETURN) begin
               // blanks only close what was open
            end else if (is_letter(b)) begin
               lex_state = bstok_pkg::MODE_IDENT;
               got[n] = make_item(bstok_pkg::KIND_IDENT, b, 1'b1, 1'b1, 1'b0);
               n++;
            end else if (is_digit(b)) begin
               lex_state = bstok_pkg::MODE_NUMBER;
               got[n] = make_item(bstok_pkg::KIND_NUMBER, b, 1'b1, 1'b1, 1'b0);
               n++;
            end else if (b == bstok_pkg::CHAR_EQUALS || b == bstok_pkg::CHAR_PLUS ||
                         b == bstok_pkg::CHAR_MINUS || b == bstok_pkg::CHAR_STAR ||
                         b == bstok_pkg::CHAR_SLASH) begin
               got[n] = make_item(bstok_pkg::KIND_OPERATOR, b, 1'b1, 1'b1, 1'b1);
               n++;
            end else if (b == bstok_pkg::CHAR_QUOTE) begin
               lex_state   = bstok_pkg::MODE_STRING;
               esc_pending = 1'b0;
               got[n] = make_item(bstok_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0);
               n++;
            end else if (b == bstok_pkg::CHAR_COMMA) begin
               got[n] = make_item(bstok_pkg::KIND_SEPARATOR, b, 1'b1, 1'b1, 1'b1);
               n++;
            end else if (b == bstok_pkg::CHAR_SEMICOLON) begin
               got[n] = make_item(bstok_pkg::KIND_EXPR_END, b, 1'b1, 1'b1, 1'b1);
               n++;
            end else begin
               got[n] = make_item(bstok_pkg::KIND_UNKNOWN, b, 1'b1, 1'b1, 1'b1);
               n++;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         got[i].last = (i == n - 1);
         if (keep) queue_expected(got[i]);
      end
   endfunction

   // mostly plausible source text, with some raw bytes mixed in
   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 11)      return 8'(8'h41 + $urandom_range(0, 25));
      else if (r < 22) return 8'(8'h61 + $urandom_range(0, 25));
      else if (r < 36) return 8'(8'h30 + $urandom_range(0, 9));
      else if (r < 44) begin
         case ($urandom_range(0, 4))
            0: return bstok_pkg::CHAR_SPACE;
            1: return bstok_pkg::CHAR_TAB;
            2: return bstok_pkg::CHAR_VTAB;
            3: return bstok_pkg::CHAR_FORMFEED;
            default: return bstok_pkg::CHAR_RETURN;
         endcase
      end else if (r < 52) begin
         case ($urandom_range(0, 4))
            0: return bstok_pkg::CHAR_EQUALS;
            1: return bstok_pkg::CHAR_PLUS;
            2: return bstok_pkg::CHAR_MINUS;
            3: return bstok_pkg::CHAR_STAR;
            default: return bstok_pkg::CHAR_SLASH;
         endcase
      end
      else if (r < 60) return bstok_pkg::CHAR_QUOTE;
      else if (r < 65) return bstok_pkg::CHAR_BACKSLASH;
      else if (r < 69) return bstok_pkg::CHAR_COMMA;
      else if (r < 72) return bstok_pkg::CHAR_SEMICOLON;
      else if (r < 80) return bstok_pkg::CHAR_NEWLINE;
      else if (r < 82) return bstok_pkg::CHAR_DOLLAR;
      else             return 8'($urandom_range(0, 255));
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(logic [7:0] b, logic eoi, row_check_type check,
                               logic [2:0] kind);
      bstok_pkg::item_type single;
      while (!calm && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_text_byte    <= b;
      req_end_of_input <= eoi;
      do @(posedge clock); while (!req_ready);
      tokenize_byte(b, eoi, check == ROW_PREDICTED);
      if (check == ROW_SINGLE) begin
         single = make_item(kind, b, 1'b1, 1'b1, 1'b1);
         single.last = 1'b1;
         queue_expected(single);
      end
      @(negedge clock);
   endtask

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 28);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token item kind %0d value %0d", $time, rsp_token_kind,
                     rsp_value_byte);
            errors++;
         end else begin
            oldest = expected_tokens.pop_front();
            compare_field("token_kind", oldest.kind, rsp_token_kind);
            compare_field("value_byte", oldest.value, rsp_value_byte);
            compare_field("has_byte", oldest.has_byte, rsp_has_byte);
            compare_field("token_start", oldest.tok_start, rsp_token_start);
            compare_field("token_end", oldest.tok_end, rsp_token_end);
            compare_field("last_result", oldest.last, rsp_last_result);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [7:0] b;
      logic       eoi;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (DIRECTED[i]) begin
         send_request(DIRECTED[i].text, DIRECTED[i].eoi, DIRECTED[i].check, DIRECTED[i].kind);
      end
      for (int idx = 0; idx < RANDOM_REQUESTS; idx++) begin
         // a long run with both sides always willing
         calm = (idx >= 300 && idx < 450);
         eoi  = ($urandom_range(0, 49) == 0);
         b    = eoi ? 8'($urandom_range(0, 255)) : pick_text_byte();
         send_request(b, eoi, ROW_PREDICTED, bstok_pkg::KIND_UNKNOWN);
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
